FILE: hdl/dnss_pkg.sv
// Shared types and constants for the domain name span scanner.
// Holds the scan state record, the byte classes and the register map.
// Has no dependencies; every other file in hdl imports it.
package dnss_pkg;

    // Default width of the length counter.
    localparam int LENGTH_BITS_DEF = 16;

    // Fixed widths of the result and configuration fields.
    localparam int SPAN_BITS     = 16;
    localparam int DOT_BITS      = 8;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // Word index of the min_dots register (byte address divided by four).
    localparam logic CFG_MIN_DOTS = 1'b0;

    // Largest value the dot counter holds.
    localparam logic [DOT_BITS-1:0] DOT_MAX = '1;

    // Characters that have a role of their own.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HIGH       = 8'h80;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // Scan phase of the current string.
    typedef enum logic [1:0] {
        PH_SCAN   = 2'd0,
        PH_STOP   = 2'd1,
        PH_REJECT = 2'd2
    } phase_t;

    // Byte classes seen by the scanner.
    typedef enum logic [2:0] {
        CC_DOT,
        CC_HYPHEN,
        CC_LETTER,
        CC_NAME,
        CC_STOP
    } char_class_t;

    // Per-string scan state, apart from the length counter.
    typedef struct packed {
        phase_t                phase;
        logic [DOT_BITS-1:0]   dot_count;
        logic                  label_all_alpha;
        logic                  dot_pending;
        logic                  saturated;
    } scan_state_t;

    // State at reset and after every result.
    localparam scan_state_t SCAN_CLEAR = '{
        phase:           PH_SCAN,
        dot_count:       '0,
        label_all_alpha: 1'b1,
        dot_pending:     1'b0,
        saturated:       1'b0
    };

endpackage

FILE: hdl/dnss_scan_core.sv
// Next-state and result logic of the domain name span scanner.
// Classifies one byte and updates the scan state; depends on dnss_pkg.
// Purely combinational; the registers live in the top level.
module dnss_scan_core
    import dnss_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic [7:0]             char_byte,
    input  scan_state_t            st,
    input  logic [LENGTH_BITS-1:0] len,
    input  logic [DOT_BITS-1:0]    min_dots,
    output scan_state_t            st_next,
    output logic [LENGTH_BITS-1:0] len_next,
    output logic                   is_term,
    output logic [SPAN_BITS-1:0]   span_length,
    output logic                   length_saturated
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX    = '1;
    localparam logic [32:0]            SPAN_LIMIT = 33'((1 << SPAN_BITS) - 1);

    // Sort a byte into the classes the scanner cares about.
    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t c;
        if (b == CH_DOT) begin
            c = CC_DOT;
        end else if (b == CH_HYPHEN) begin
            c = CC_HYPHEN;
        end else if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
                     (b >= CH_UPPER_A && b <= CH_UPPER_Z)) begin
            c = CC_LETTER;
        end else if (b == CH_UNDERSCORE || b >= CH_HIGH ||
                     (b >= CH_DIGIT_0 && b <= CH_DIGIT_9)) begin
            c = CC_NAME;
        end else begin
            c = CC_STOP;
        end
        return c;
    endfunction

    char_class_t            cls;
    logic                   count_en;
    logic                   double_dot;
    logic [LENGTH_BITS-1:0] span_raw;
    logic [32:0]            span_wide;
    logic                   span_clamp;

    assign cls        = classify(char_byte);
    assign is_term    = (char_byte == CH_NUL);
    assign double_dot = st.dot_pending && (cls == CC_DOT);

    // State update for one accepted byte.
    always_comb begin
        st_next  = st;
        len_next = len;
        count_en = 1'b0;
        if (is_term) begin
            st_next  = SCAN_CLEAR;
            len_next = '0;
        end else if (st.phase == PH_SCAN) begin
            // Resolve a dot held from the previous byte.
            if (st.dot_pending) begin
                st_next.dot_pending = 1'b0;
                if (double_dot) begin
                    st_next.phase = PH_REJECT;
                end else begin
                    st_next.label_all_alpha = 1'b1;
                    if (st.dot_count != DOT_MAX) begin
                        st_next.dot_count = st.dot_count + 1'b1;
                    end
                end
            end
            if (!double_dot) begin
                unique case (cls)
                    CC_DOT: begin
                        count_en            = 1'b1;
                        st_next.dot_pending = 1'b1;
                    end
                    CC_HYPHEN: begin
                        count_en = 1'b1;
                    end
                    CC_LETTER: begin
                        count_en = 1'b1;
                    end
                    CC_NAME: begin
                        count_en                = 1'b1;
                        st_next.label_all_alpha = 1'b0;
                    end
                    CC_STOP: begin
                        st_next.phase = PH_STOP;
                    end
                    default: begin
                        st_next.phase = PH_STOP;
                    end
                endcase
            end
            // Saturating length count.
            if (count_en) begin
                if (len != LEN_MAX) begin
                    len_next = len + 1'b1;
                end
                if (len_next == LEN_MAX) begin
                    st_next.saturated = 1'b1;
                end
            end
        end
    end

    // Span reported at the terminator.
    always_comb begin
        span_raw = '0;
        unique case (st.phase)
            PH_SCAN: begin
                if (!(st.dot_count != '0 && !st.label_all_alpha) &&
                    st.dot_count >= min_dots) begin
                    span_raw = len;
                end
            end
            PH_STOP: begin
                if (st.dot_count >= min_dots) begin
                    span_raw = len;
                end
            end
            PH_REJECT: begin
                span_raw = '0;
            end
            default: begin
                span_raw = '0;
            end
        endcase
    end

    // Clamp to the width of the result field.
    assign span_wide        = 33'(span_raw);
    assign span_clamp       = (span_wide > SPAN_LIMIT);
    assign span_length      = span_clamp ? '1 : span_wide[SPAN_BITS-1:0];
    assign length_saturated = st.saturated | span_clamp;

endmodule

FILE: hdl/domain_name_span_scanner_unit.sv
// Top level of the domain name span scanner: state, result and APB registers.
// Instantiates dnss_scan_core; depends on dnss_pkg.
// Assertions at the end are left out when NO_ASSERTIONS is defined.

// The scanner takes one string byte per request, one request every clock
// cycle, and answers each zero terminator with one result: the length of the
// valid domain-name prefix (0 for a rejected string) and a saturation flag.
// The result appears on the m_ channel in the cycle after the terminator is
// accepted. Byte classification and the state update are combinational between
// the scan state registers and the result register, so the sustained rate is
// one byte per cycle; input stalls only while a result waits for m_ready.
// min_dots sits at byte address 0 of the APB port and may be written only
// while no string is in progress.
module domain_name_span_scanner_unit
    import dnss_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Byte channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_char_byte,
    // Result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SPAN_BITS-1:0]     m_span_length,
    output logic                     m_length_saturated,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    scan_state_t            st_reg;
    scan_state_t            st_next;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] len_next;
    logic [DOT_BITS-1:0]    min_dots_reg;
    logic                   m_valid_reg;
    logic [SPAN_BITS-1:0]   span_reg;
    logic                   sat_reg;
    logic                   is_term;
    logic [SPAN_BITS-1:0]   span_next;
    logic                   sat_next;
    logic                   in_fire;
    logic                   cfg_sel;

    // Byte classification and next state.
    dnss_scan_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .char_byte        (s_char_byte),
        .st               (st_reg),
        .len              (len_reg),
        .min_dots         (min_dots_reg),
        .st_next          (st_next),
        .len_next         (len_next),
        .is_term          (is_term),
        .span_length      (span_next),
        .length_saturated (sat_next)
    );

    // A new byte is taken whenever the result register is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    // Scan state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= SCAN_CLEAR;
            len_reg <= '0;
        end else if (in_fire) begin
            st_reg  <= st_next;
            len_reg <= len_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire && is_term) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && is_term) begin
            span_reg <= span_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_span_length      = span_reg;
    assign m_length_saturated = sat_reg;

    // APB register file: one register, min_dots.
    assign cfg_sel = (paddr[CFG_ADDR_BITS-1] == CFG_MIN_DOTS);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dots_reg <= '0;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            min_dots_reg <= pwdata[DOT_BITS-1:0];
        end
    end

    assign prdata = cfg_sel ? CFG_DATA_BITS'(min_dots_reg) : '0;

`ifndef NO_ASSERTIONS
    // A terminator always produces a result in the next cycle.
    a_term_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_char_byte == CH_NUL) |=> m_valid)
        else $error("terminator accepted without a result");

    // A terminator clears the scan state for the next string.
    a_term_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_char_byte == CH_NUL) |=>
        (len_reg == '0 && st_reg == SCAN_CLEAR))
        else $error("scan state not cleared after terminator");

    // A pending dot exists only while the string is still being scanned.
    a_pending_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.dot_pending |-> (st_reg.phase == PH_SCAN))
        else $error("dot pending outside the scanning phase");

    // The length counter reaches its maximum only with the flag set.
    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == LEN_MAX) |-> st_reg.saturated)
        else $error("length at maximum without saturation flag");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for domain_name_span_scanner_unit.
// Streams byte strings, predicts each span result and checks the APB min_dots register.
// Depends on dnss_pkg and the RTL in hdl; needs nothing else.
module tb_top;
    import dnss_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 120;
    localparam logic [CFG_ADDR_BITS-1:0] MIN_DOTS_ADDR = {CFG_MIN_DOTS, 2'b00};

    typedef struct {
        logic [SPAN_BITS-1:0] span_length;
        logic                 length_saturated;
    } span_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [7:0]               s_char_byte;
    logic                     m_valid;
    logic                     m_ready;
    logic [SPAN_BITS-1:0]     m_span_length;
    logic                     m_length_saturated;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Bytes waiting to be sent and span results waiting to be seen.
    logic [7:0]   pending_bytes[$];
    span_result_t expected_spans[$];

    // Predicted scan state and the register copy it uses.
    logic [7:0]          min_dots_cfg;
    logic [15:0]         len_cnt;
    logic [DOT_BITS-1:0] dot_cnt;
    logic                label_alpha;
    logic                dot_pend;
    logic                sat_seen;
    phase_t              scan_ph;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  byte_taken;
    int  cycle_count;
    int  fail_count;
    int  bytes_sent;
    int  spans_checked;
    int  cfg_writes;

    domain_name_span_scanner_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_byte        (s_char_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_span_length      (m_span_length),
        .m_length_saturated (m_length_saturated),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Clock with a 20-unit period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Sort a non-zero byte into the classes the scanner tells apart.
    function automatic char_class_t classify_byte(input logic [7:0] b);
        if (b == CH_DOT)
            return CC_DOT;
        if (b == CH_HYPHEN)
            return CC_HYPHEN;
        if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z))
            return CC_LETTER;
        if (b == CH_UNDERSCORE || b >= CH_HIGH || (b >= CH_DIGIT_0 && b <= CH_DIGIT_9))
            return CC_NAME;
        return CC_STOP;
    endfunction

    function automatic void clear_scan_state();
        len_cnt     = '0;
        dot_cnt     = '0;
        label_alpha = 1'b1;
        dot_pend    = 1'b0;
        sat_seen    = 1'b0;
        scan_ph     = PH_SCAN;
    endfunction

    // Advance the predicted scan by one accepted byte; a terminator yields a span.
    function automatic void advance_scan(input logic [7:0] b);
        span_result_t res;
        char_class_t  cls;
        if (b == CH_NUL) begin
            res.span_length = '0;
            if (scan_ph == PH_SCAN) begin
                if (!(dot_cnt != 0 && !label_alpha) && dot_cnt >= min_dots_cfg)
                    res.span_length = len_cnt;
            end else if (scan_ph == PH_STOP) begin
                if (dot_cnt >= min_dots_cfg)
                    res.span_length = len_cnt;
            end
            res.length_saturated = sat_seen;
            expected_spans.push_back(res);
            clear_scan_state();
            return;
        end
        if (scan_ph != PH_SCAN)
            return;
        // A held dot is resolved by the byte after it.
        if (dot_pend) begin
            dot_pend = 1'b0;
            if (b == CH_DOT) begin
                scan_ph = PH_REJECT;
                return;
            end
            label_alpha = 1'b1;
            if (dot_cnt != DOT_MAX)
                dot_cnt++;
        end
        cls = classify_byte(b);
        if (cls == CC_STOP) begin
            scan_ph = PH_STOP;
            return;
        end
        if (len_cnt != 16'hFFFF)
            len_cnt++;
        if (len_cnt == 16'hFFFF)
            sat_seen = 1'b1;
        if (cls == CC_DOT)
            dot_pend = 1'b1;
        else if (cls == CC_NAME)
            label_alpha = 1'b0;
    endfunction

    // Accept a request, predict from it, then check any result against the oldest span.
    always @(posedge aclk) begin
        span_result_t want;
        cycle_count++;
        byte_taken = aresetn && s_valid && s_ready;
        if (byte_taken) begin
            advance_scan(s_char_byte);
            bytes_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_spans.size() == 0) begin
                $error("Unexpected result: span_length %0d, length_saturated %0b",
                       m_span_length, m_length_saturated);
                fail_count++;
            end else begin
                want = expected_spans.pop_front();
                spans_checked++;
                if (m_span_length !== want.span_length) begin
                    $error("span_length: expected %0d, actual %0d",
                           want.span_length, m_span_length);
                    fail_count++;
                end
                if (m_length_saturated !== want.length_saturated) begin
                    $error("length_saturated: expected %0b, actual %0b",
                           want.length_saturated, m_length_saturated);
                    fail_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Drive the byte channel and the result back-pressure at the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid     <= 1'b1;
                s_char_byte <= pending_bytes.pop_front();
            end else begin
                s_valid     <= 1'b0;
                s_char_byte <= 8'($urandom_range(255));
            end
        end
    end

    // Queue a text string followed by its terminator.
    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            pending_bytes.push_back(text[i]);
        pending_bytes.push_back(CH_NUL);
    endtask

    // Queue a name made of single-letter labels with the given number of dots.
    task automatic queue_dotted_name(input int n_dots);
        pending_bytes.push_back(CH_LOWER_A);
        for (int i = 0; i < n_dots; i++) begin
            pending_bytes.push_back(CH_DOT);
            pending_bytes.push_back(CH_LOWER_A);
        end
        pending_bytes.push_back(CH_NUL);
    endtask

    function automatic logic [7:0] pick_name_byte(input bit letters_only);
        int r;
        r = $urandom_range(9);
        if (letters_only || r < 5)
            return $urandom_range(1) ? 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z))
                                     : 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
        if (r < 7)
            return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
        if (r == 7)
            return CH_HYPHEN;
        if (r == 8)
            return CH_UNDERSCORE;
        return 8'($urandom_range(CH_HIGH, 255));
    endfunction

    // Mostly well-formed names with random content, the rest broken or noise.
    task automatic queue_random_name();
        int         n_labels;
        int         lab_len;
        bit         alpha_tail;
        logic [7:0] stop_byte;
        n_labels = $urandom_range(1, 5);
        if ($urandom_range(99) < 75) begin
            alpha_tail = ($urandom_range(3) != 0);
            for (int l = 0; l < n_labels; l++) begin
                if (l > 0) begin
                    pending_bytes.push_back(CH_DOT);
                    if ($urandom_range(29) == 0)
                        pending_bytes.push_back(CH_DOT);
                end
                lab_len = $urandom_range(1, 8);
                for (int k = 0; k < lab_len; k++)
                    pending_bytes.push_back(pick_name_byte(l == n_labels - 1 && alpha_tail));
            end
            if ($urandom_range(9) == 0)
                pending_bytes.push_back(CH_DOT);
            // A stop byte followed by bytes the scanner must ignore.
            if ($urandom_range(9) == 0) begin
                do
                    stop_byte = 8'($urandom_range(1, 127));
                while (classify_byte(stop_byte) != CC_STOP);
                pending_bytes.push_back(stop_byte);
                repeat ($urandom_range(0, 4))
                    pending_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end else begin
            repeat ($urandom_range(0, 12))
                pending_bytes.push_back($urandom_range(3) == 0 ? CH_DOT
                                                               : 8'($urandom_range(1, 255)));
        end
        pending_bytes.push_back(CH_NUL);
    endtask

    // Let every queued byte go out and every predicted span come back.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_valid || expected_spans.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Read min_dots over APB and compare with the expected value.
    task automatic check_min_dots(input logic [7:0] value);
        logic [CFG_DATA_BITS-1:0] readback;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MIN_DOTS_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== CFG_DATA_BITS'(value)) begin
            $error("min_dots: expected %0d, actual %0d", value, readback);
            fail_count++;
        end
    endtask

    // Write min_dots over APB, then read it back.
    task automatic write_min_dots(input logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_DOTS_ADDR;
        pwdata  <= CFG_DATA_BITS'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_dots_cfg = value;
        cfg_writes++;
        check_min_dots(value);
    endtask

    // Reset, directed cases, then three random phases with different idling.
    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_char_byte   = '0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 29;
        recv_idle_pct = 77;
        byte_taken    = 1'b0;
        cycle_count   = 0;
        fail_count    = 0;
        bytes_sent    = 0;
        spans_checked = 0;
        cfg_writes    = 0;
        min_dots_cfg  = '0;
        clear_scan_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_min_dots(8'd0);

        // Directed: plain name, double dot, trailing dot, numeric last label,
        // stop byte with ignored tail, high-bit bytes, empty string.
        queue_text("a.b");
        queue_text("a..b");
        queue_text("x.");
        queue_text("1.2");
        queue_text("ab!.9");
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(CH_HIGH);
        queue_text("-_Z");
        queue_text("");
        wait_drained();

        // Largest min_dots: dot counter saturation passes, a short count fails.
        write_min_dots(8'd255);
        queue_dotted_name(256);
        queue_dotted_name(3);
        wait_drained();

        // Sender idles lightly, receiver heavily.
        write_min_dots(8'd1);
        send_idle_pct = 29;
        recv_idle_pct = 77;
        while (pending_bytes.size() < RANDOM_BYTES)
            queue_random_name();
        wait_drained();

        // Roles swapped.
        write_min_dots(8'($urandom_range(2, 3)));
        send_idle_pct = 77;
        recv_idle_pct = 29;
        while (pending_bytes.size() < RANDOM_BYTES)
            queue_random_name();
        wait_drained();

        // Full rate on both sides.
        write_min_dots(8'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pending_bytes.size() < RANDOM_BYTES)
            queue_random_name();
        wait_drained();

        $display("Sent %0d bytes and checked %0d span results under %0d min_dots writes,",
                 bytes_sent, spans_checked, cfg_writes);
        $display("covering both idling mixes, full rate and dot counter saturation.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dnss_pkg.sv
hdl/dnss_scan_core.sv
hdl/domain_name_span_scanner_unit.sv
dv/tb_top.sv
